// File: rtl/mbs_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the maze backtracker step core.
// No dependencies; used by the top level, mbs_pick and mbs_checker.
package mbs_pkg;

   localparam int COORD_W = 5;

   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   localparam logic [1:0] OUTCOME_STARTED = 2'd0;
   localparam logic [1:0] OUTCOME_CARVED  = 2'd1;
   localparam logic [1:0] OUTCOME_BACK    = 2'd2;
   localparam logic [1:0] OUTCOME_IGNORED = 2'd3;

   localparam logic [1:0] DIR_NORTH = 2'd0;
   localparam logic [1:0] DIR_EAST  = 2'd1;
   localparam logic [1:0] DIR_SOUTH = 2'd2;
   localparam logic [1:0] DIR_WEST  = 2'd3;

   typedef struct packed {
      logic        operation;
      logic [15:0] random_value;
   } req_type;

   typedef struct packed {
      logic [1:0]         outcome;
      logic [1:0]         heading;
      logic [COORD_W-1:0] from_col;
      logic [COORD_W-1:0] from_row;
      logic [COORD_W-1:0] to_col;
      logic [COORD_W-1:0] to_row;
      logic               finished;
   } rsp_type;

   // Result of the direction choice.
   typedef struct packed {
      logic       found;
      logic [1:0] dir;
   } pick_type;

endpackage

// File: rtl/maze_backtracker_step_core.sv
`timescale 1ns / 1ps
// Top level of the maze backtracker step core: sequencer, position stack
// and visited map. Depends on mbs_pkg, mbs_ram and mbs_pick.

// One item is in flight at a time; req_stall is high from acceptance until
// the result item is taken. A step item reads the four neighbors of the
// current cell one after another from the single read port of the visited
// memory, then chooses and writes; a backtrack with a non-empty stack also
// reads the top of the stack memory, and a step taken while no maze is
// active is ignored without any reads. A start item sweeps the whole visited
// memory, one entry a cycle, all (1 << 2*clog2(MAX_SIDE)) entries, 1024
// at the default MAX_SIDE of 32. maze_side is sampled when a start item is
// accepted and is clamped to the range 2 to MAX_SIDE.
module maze_backtracker_step_core #(
   parameter int MAX_SIDE = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mbs_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mbs_pkg::rsp_type rsp_item,
   input  logic             csr_wr_en,
   input  logic [5:0]       csr_wr_data
);

   localparam int CW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int AW    = 2 * CW;
   localparam int DEPTH = 1 << AW;
   localparam int SW    = $clog2(MAX_SIDE + 1);
   localparam int CELLS = MAX_SIDE * MAX_SIDE;
   localparam int TW    = $clog2(CELLS + 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CLEAR  = 3'd1;
   localparam logic [2:0] S_READ   = 3'd2;
   localparam logic [2:0] S_DECIDE = 3'd3;
   localparam logic [2:0] S_POP    = 3'd4;
   localparam logic [2:0] S_RESP   = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [5:0]    maze_side_ff, maze_side_in;
   logic [SW-1:0] side_ff, side_in;
   logic [TW-1:0] side_sq_ff, side_sq_in;
   logic [TW-1:0] total_ff, total_in;
   logic [TW-1:0] depth_ff, depth_in;
   logic          active_ff, active_in;
   logic [CW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] from_row_ff, from_row_in;
   logic [CW-1:0] from_col_ff, from_col_in;
   logic [15:0]   rnd_ff, rnd_in;
   logic [2:0]    cnt_ff, cnt_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [3:0]    unvis_ff, unvis_in;
   logic [1:0]    outcome_ff, outcome_in;
   logic [1:0]    heading_ff, heading_in;

   logic [SW-1:0] side_clamp;
   logic [3:0]    in_bounds;
   logic [CW-1:0] nb_row, nb_col;
   logic [CW-1:0] dest_row, dest_col;
   logic [TW-1:0] total_inc;
   logic          finished;

   logic          vis_wr_en;
   logic [AW-1:0] vis_wr_addr;
   logic          vis_wr_data;
   logic          vis_rd_data;
   logic          stk_wr_en;
   logic [AW-1:0] stk_rd_addr;
   logic [AW-1:0] stk_rd_data;

   mbs_pkg::pick_type pick;

   always_comb begin
      if (maze_side_ff < 6'd2) begin
         side_clamp = SW'(2);
      end else if (int'(maze_side_ff) > MAX_SIDE) begin
         side_clamp = SW'(MAX_SIDE);
      end else begin
         side_clamp = SW'(maze_side_ff);
      end
   end

   assign in_bounds[mbs_pkg::DIR_NORTH] = (row_ff != '0);
   assign in_bounds[mbs_pkg::DIR_EAST]  = (SW'(col_ff) + SW'(1) < side_ff);
   assign in_bounds[mbs_pkg::DIR_SOUTH] = (SW'(row_ff) + SW'(1) < side_ff);
   assign in_bounds[mbs_pkg::DIR_WEST]  = (col_ff != '0);

   // Neighbor address for the read issued this cycle.
   always_comb begin
      nb_row = row_ff;
      nb_col = col_ff;
      case (cnt_ff[1:0])
         mbs_pkg::DIR_NORTH: nb_row = row_ff - CW'(1);
         mbs_pkg::DIR_EAST:  nb_col = col_ff + CW'(1);
         mbs_pkg::DIR_SOUTH: nb_row = row_ff + CW'(1);
         mbs_pkg::DIR_WEST:  nb_col = col_ff - CW'(1);
         default: ;
      endcase
   end

   mbs_pick u_pick (
      .open_dirs    (unvis_ff & in_bounds),
      .random_value (rnd_ff),
      .pick         (pick)
   );

   always_comb begin
      dest_row = row_ff;
      dest_col = col_ff;
      case (pick.dir)
         mbs_pkg::DIR_NORTH: dest_row = row_ff - CW'(1);
         mbs_pkg::DIR_EAST:  dest_col = col_ff + CW'(1);
         mbs_pkg::DIR_SOUTH: dest_row = row_ff + CW'(1);
         mbs_pkg::DIR_WEST:  dest_col = col_ff - CW'(1);
         default: ;
      endcase
   end

   assign total_inc = total_ff + TW'(1);
   assign finished  = (total_ff != '0) && (total_ff == side_sq_ff);

   always_comb begin
      state_in     = state_ff;
      maze_side_in = csr_wr_en ? csr_wr_data : maze_side_ff;
      side_in      = side_ff;
      side_sq_in   = side_sq_ff;
      total_in     = total_ff;
      depth_in     = depth_ff;
      active_in    = active_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      from_row_in  = from_row_ff;
      from_col_in  = from_col_ff;
      rnd_in       = rnd_ff;
      cnt_in       = cnt_ff;
      clr_in       = clr_ff;
      unvis_in     = unvis_ff;
      outcome_in   = outcome_ff;
      heading_in   = heading_ff;
      vis_wr_en    = 1'b0;
      vis_wr_addr  = {dest_row, dest_col};
      vis_wr_data  = 1'b1;
      stk_wr_en    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               from_row_in = row_ff;
               from_col_in = col_ff;
               rnd_in      = req_item.random_value;
               heading_in  = mbs_pkg::DIR_NORTH;
               cnt_in      = 3'd0;
               if (req_item.operation == mbs_pkg::OP_START) begin
                  side_in     = side_clamp;
                  side_sq_in  = TW'(side_clamp) * TW'(side_clamp);
                  total_in    = TW'(1);
                  depth_in    = '0;
                  active_in   = 1'b1;
                  row_in      = '0;
                  col_in      = '0;
                  from_row_in = '0;
                  from_col_in = '0;
                  clr_in      = '0;
                  outcome_in  = mbs_pkg::OUTCOME_STARTED;
                  state_in    = S_CLEAR;
               end else if (!active_ff) begin
                  outcome_in = mbs_pkg::OUTCOME_IGNORED;
                  state_in   = S_RESP;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_CLEAR: begin
            // Wipe the map; the origin comes out visited.
            vis_wr_en   = 1'b1;
            vis_wr_addr = clr_ff;
            vis_wr_data = (clr_ff == '0);
            clr_in      = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = S_RESP;
            end
         end
         S_READ: begin
            // Read for neighbor cnt lands in the next cycle, so this data is for cnt - 1.
            if (cnt_ff != 3'd0) begin
               unvis_in[cnt_ff[1:0] - 2'd1] = !vis_rd_data;
            end
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd4) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (pick.found) begin
               vis_wr_en = 1'b1;
               if (depth_ff < TW'(CELLS)) begin
                  stk_wr_en = 1'b1;
                  depth_in  = depth_ff + TW'(1);
               end
               row_in     = dest_row;
               col_in     = dest_col;
               total_in   = total_inc;
               active_in  = (total_inc != side_sq_ff);
               outcome_in = mbs_pkg::OUTCOME_CARVED;
               heading_in = pick.dir;
               state_in   = S_RESP;
            end else begin
               outcome_in = mbs_pkg::OUTCOME_BACK;
               if (depth_ff != '0) begin
                  depth_in = depth_ff - TW'(1);
                  state_in = S_POP;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_POP: begin
            row_in   = stk_rd_data[AW-1:CW];
            col_in   = stk_rd_data[CW-1:0];
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         maze_side_ff <= 6'd16;
         side_ff      <= '0;
         side_sq_ff   <= '0;
         total_ff     <= '0;
         depth_ff     <= '0;
         active_ff    <= 1'b0;
         row_ff       <= '0;
         col_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         maze_side_ff <= maze_side_in;
         side_ff      <= side_in;
         side_sq_ff   <= side_sq_in;
         total_ff     <= total_in;
         depth_ff     <= depth_in;
         active_ff    <= active_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      from_row_ff <= from_row_in;
      from_col_ff <= from_col_in;
      rnd_ff      <= rnd_in;
      cnt_ff      <= cnt_in;
      clr_ff      <= clr_in;
      unvis_ff    <= unvis_in;
      outcome_ff  <= outcome_in;
      heading_ff  <= heading_in;
   end

   mbs_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
   ) u_visited (
      .clock   (clock),
      .wr_en   (vis_wr_en),
      .wr_addr (vis_wr_addr),
      .wr_data (vis_wr_data),
      .rd_addr ({nb_row, nb_col}),
      .rd_data (vis_rd_data)
   );

   // Read address is the top of stack; the pop consumes it in the next cycle.
   assign stk_rd_addr = AW'(depth_ff - TW'(1));

   mbs_ram #(
      .WIDTH (AW),
      .DEPTH (DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (AW'(depth_ff)),
      .wr_data ({row_ff, col_ff}),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   always_comb begin
      rsp_item.outcome  = outcome_ff;
      rsp_item.heading  = heading_ff;
      rsp_item.from_col = mbs_pkg::COORD_W'(from_col_ff);
      rsp_item.from_row = mbs_pkg::COORD_W'(from_row_ff);
      rsp_item.to_col   = mbs_pkg::COORD_W'(col_ff);
      rsp_item.to_row   = mbs_pkg::COORD_W'(row_ff);
      rsp_item.finished = finished;
   end

endmodule

// File: rtl/mbs_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mbs_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/mbs_pick.sv
`timescale 1ns / 1ps
// Direction choice: takes the open-neighbor mask and a random value,
// returns the chosen heading. Depends on mbs_pkg.
module mbs_pick (
   input  logic [3:0]       open_dirs,
   input  logic [15:0]      random_value,
   output mbs_pkg::pick_type pick
);

   // Base-4 digits are each worth 1 mod 3, so fold digit sums.
   function automatic logic [1:0] mod3(input logic [15:0] v);
      logic [4:0] s;
      logic [2:0] t;
      logic [2:0] u;
      s = 5'd0;
      for (int i = 0; i < 8; i++) begin
         s = s + 5'(v[2*i +: 2]);
      end
      t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
      u = 3'(t[1:0]) + 3'(t[2]);
      if (u >= 3'd3) begin
         u = u - 3'd3;
      end
      return u[1:0];
   endfunction

   logic [2:0] count;
   logic [1:0] rank;
   logic [2:0] seen;

   assign count = 3'($countones(open_dirs));

   always_comb begin
      case (count)
         3'd2:    rank = {1'b0, random_value[0]};
         3'd3:    rank = mod3(random_value);
         3'd4:    rank = random_value[1:0];
         default: rank = 2'd0;
      endcase
   end

   // Take the rank-th open direction in north, east, south, west order.
   always_comb begin
      pick.found = 1'b0;
      pick.dir   = mbs_pkg::DIR_NORTH;
      seen       = 3'd0;
      for (int i = 0; i < 4; i++) begin
         if (open_dirs[i]) begin
            if (!pick.found && seen == {1'b0, rank}) begin
               pick.found = 1'b1;
               pick.dir   = 2'(i);
            end
            seen = seen + 3'd1;
         end
      end
   end

endmodule

// File: rtl/mbs_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the maze backtracker step core, bound to the top.
// Depends on mbs_pkg and maze_backtracker_step_core.
module mbs_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input mbs_pkg::rsp_type rsp_item
);

   logic [4:0] row_up, row_down, col_left, col_right;
   logic       moved_ok;
   logic       same_cell;

   assign row_up    = rsp_item.from_row - 5'd1;
   assign row_down  = rsp_item.from_row + 5'd1;
   assign col_left  = rsp_item.from_col - 5'd1;
   assign col_right = rsp_item.from_col + 5'd1;
   assign same_cell = (rsp_item.to_row == rsp_item.from_row)
                   && (rsp_item.to_col == rsp_item.from_col);

   always_comb begin
      case (rsp_item.heading)
         mbs_pkg::DIR_NORTH:
            moved_ok = (rsp_item.to_row == row_up) && (rsp_item.to_col == rsp_item.from_col);
         mbs_pkg::DIR_EAST:
            moved_ok = (rsp_item.to_col == col_right) && (rsp_item.to_row == rsp_item.from_row);
         mbs_pkg::DIR_SOUTH:
            moved_ok = (rsp_item.to_row == row_down) && (rsp_item.to_col == rsp_item.from_col);
         mbs_pkg::DIR_WEST:
            moved_ok = (rsp_item.to_col == col_left) && (rsp_item.to_row == rsp_item.from_row);
         default:
            moved_ok = 1'b0;
      endcase
   end

   // Result held while stalled.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("result item changed while stalled");

   // One item at a time: busy after acceptance and while a result waits.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken again before result delivered");

   a_no_accept_with_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while result pending");

   // A carve moves exactly one cell in the reported heading.
   a_carve_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.outcome == mbs_pkg::OUTCOME_CARVED |-> moved_ok)
      else $error("carve result does not move one cell in its heading");

   // Ignored and started items leave the walker in place with heading north.
   a_stay_put: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.outcome == mbs_pkg::OUTCOME_IGNORED
                    || rsp_item.outcome == mbs_pkg::OUTCOME_STARTED)
      |-> same_cell && rsp_item.heading == mbs_pkg::DIR_NORTH)
      else $error("ignored or start result moved the walker");

endmodule

bind maze_backtracker_step_core mbs_checker u_mbs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);
